// ===== hw/rtl/rfs_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, operation codes and types for the reversible search FIFO.
package rfs_pkg;

    localparam int WORD_W        = 32;
    localparam int OP_W          = 2;
    localparam int OCC_W         = 5;
    localparam int FOUND_W       = 5;
    localparam int DEPTH_DEFAULT = 16;

    typedef logic [OP_W-1:0]    op_t;
    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [OCC_W-1:0]   occ_t;
    typedef logic [FOUND_W-1:0] found_t;

    localparam op_t OP_ENQ  = 2'd0;
    localparam op_t OP_DEQ  = 2'd1;
    localparam op_t OP_REV  = 2'd2;
    localparam op_t OP_FIND = 2'd3;

    // All-ones words stand for -1 in the result fields.
    localparam word_t  WORD_EMPTY = '1;
    localparam found_t FOUND_NONE = '1;

endpackage

// ===== hw/rtl/rfs_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for operation requests and status results.
interface rfs_in_if
    import rfs_pkg::*;
();
    logic               valid;
    logic               ready;
    op_t                op;
    logic signed [31:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface rfs_out_if
    import rfs_pkg::*;
();
    logic               valid;
    logic               ready;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    occ_t               occupancy;
    logic signed [4:0]  found_index;
    logic               overflow_drop;

    modport source (output valid, output front_value, output back_value, output occupancy,
                    output found_index, output overflow_drop, input ready);
    modport sink   (input valid, input front_value, input back_value, input occupancy,
                    input found_index, input overflow_drop, output ready);
endinterface

// ===== hw/rtl/rfs_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module rfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold read data while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/reversible_fifo_with_search_core.sv =====
`timescale 1ns / 1ps
// Top level of the reversible FIFO with value search.
// Usage
//   cmd carries one request per transfer: op selects enqueue, dequeue,
//   reverse or find, and value is the word to enqueue or to look for.
//   rsp returns exactly one status transfer per request: front and back
//   words (-1 when empty), occupancy, the index of the first match for a
//   find (-1 otherwise or when absent) and the overflow drop flag.
// Operation sequence
//   Enqueue, dequeue and reverse show their status on rsp after the
//   operation cycle, reads of the front and back slots on the single RAM
//   read port and a final state that loads the output register once it is
//   free. Find first walks the stored words one per cycle through the same
//   port, stopping at the first match, before the same reads. One request is
//   in flight at a time and cmd.ready is high only while idle; the block
//   returns to idle as the status is loaded into the output register.
// Reset
//   rst_n clears head, count and direction at once; the word store keeps its contents.
// Backpressure
//   The status sits in an output register, so a new request is taken while
//   rsp is stalled; the block then holds the next status until it drains.
module reversible_fifo_with_search_core
    import rfs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    rfs_in_if.sink    cmd,
    rfs_out_if.source rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FIND = 3'd1;
    localparam logic [2:0] S_RDF  = 3'd2;
    localparam logic [2:0] S_RDB  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // Physical slot of logical position pos, taken modulo DEPTH.
    // pos is at most DEPTH, so one correction step suffices.
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [CW-1:0] pos,
                                              input logic          rev);
        logic [AW:0] h;
        logic [AW:0] p;
        logic [AW:0] s;
        h = {1'b0, head};
        p = (AW + 1)'(pos);
        if (rev)
        begin
            if (h >= p)
            begin
                s = h - p;
            end
            else
            begin
                s = h + DEPTH_W - p;
            end
        end
        else
        begin
            s = h + p;
            if (s >= DEPTH_W)
            begin
                s = s - DEPTH_W;
            end
        end
        return s[AW-1:0];
    endfunction

    // Control state
    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic          rev_reg, rev_next;
    logic [CW-1:0] issue_reg, issue_next;
    logic          cmp_valid_reg, cmp_valid_next;
    logic          rsp_valid_reg, rsp_valid_next;

    // Payload state
    word_t         value_reg, value_next;
    logic [AW-1:0] cmp_idx_reg, cmp_idx_next;
    found_t        found_reg, found_next;
    logic          drop_reg, drop_next;
    word_t         front_reg, front_next;
    word_t         out_front_reg, out_front_next;
    word_t         out_back_reg, out_back_next;
    occ_t          out_occ_reg, out_occ_next;
    found_t        out_found_reg, out_found_next;
    logic          out_drop_reg, out_drop_next;

    // RAM port
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    word_t         wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    word_t         rd_data;

    logic [CW-1:0] last_pos;

    rfs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Logical position of the back word; clamp to zero when empty.
    assign last_pos = (count_reg == '0) ? '0 : count_reg - 1'b1;

    assign cmd.ready = (state_reg == S_IDLE);

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.front_value   = $signed(out_front_reg);
    assign rsp.back_value    = $signed(out_back_reg);
    assign rsp.occupancy     = out_occ_reg;
    assign rsp.found_index   = $signed(out_found_reg);
    assign rsp.overflow_drop = out_drop_reg;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        rev_next       = rev_reg;
        issue_next     = issue_reg;
        cmp_valid_next = cmp_valid_reg;
        value_next     = value_reg;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        drop_next      = drop_reg;
        front_next     = front_reg;
        out_front_next = out_front_reg;
        out_back_next  = out_back_reg;
        out_occ_next   = out_occ_reg;
        out_found_next = out_found_reg;
        out_drop_next  = out_drop_reg;

        wr_en   = 1'b0;
        wr_addr = slot_of(head_reg, count_reg, rev_reg);
        wr_data = word_t'(cmd.value);
        rd_en   = 1'b0;
        rd_addr = head_reg;

        // Drop the held status once the receiver takes it.
        rsp_valid_next = rsp_valid_reg && !rsp.ready;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    value_next     = word_t'(cmd.value);
                    found_next     = FOUND_NONE;
                    drop_next      = 1'b0;
                    issue_next     = '0;
                    cmp_valid_next = 1'b0;
                    state_next     = S_RDF;
                    case (cmd.op)
                        OP_ENQ:
                        begin
                            if (count_reg == DEPTH_C)
                            begin
                                drop_next = 1'b1;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_DEQ:
                        begin
                            if (count_reg != '0)
                            begin
                                head_next  = slot_of(head_reg, CW'(1), rev_reg);
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_REV:
                        begin
                            // The old back becomes the head; flip the walk direction.
                            if (count_reg != '0)
                            begin
                                head_next = slot_of(head_reg, last_pos, rev_reg);
                                rev_next  = !rev_reg;
                            end
                        end
                        OP_FIND:
                        begin
                            state_next = S_FIND;
                        end
                        default:
                        begin
                            state_next = S_RDF;
                        end
                    endcase
                end
            end

            S_FIND:
            begin
                // Issue one read per cycle and compare the word read the cycle before.
                rd_en          = (issue_reg < count_reg);
                rd_addr        = slot_of(head_reg, issue_reg, rev_reg);
                cmp_valid_next = rd_en;
                cmp_idx_next   = issue_reg[AW-1:0];
                if (rd_en)
                begin
                    issue_next = issue_reg + 1'b1;
                end
                if (cmp_valid_reg && (rd_data == value_reg))
                begin
                    found_next = FOUND_W'(cmp_idx_reg);
                    state_next = S_RDF;
                end
                else if (!rd_en && !cmp_valid_reg)
                begin
                    state_next = S_RDF;
                end
            end

            S_RDF:
            begin
                rd_en      = 1'b1;
                rd_addr    = head_reg;
                state_next = S_RDB;
            end

            S_RDB:
            begin
                rd_en      = 1'b1;
                rd_addr    = slot_of(head_reg, last_pos, rev_reg);
                front_next = rd_data;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // Hold here until the output register is free.
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    out_front_next = (count_reg == '0) ? WORD_EMPTY : front_reg;
                    out_back_next  = (count_reg == '0) ? WORD_EMPTY : rd_data;
                    out_occ_next   = OCC_W'(count_reg);
                    out_found_next = found_reg;
                    out_drop_next  = drop_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            issue_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            rev_reg       <= rev_next;
            issue_reg     <= issue_next;
            cmp_valid_reg <= cmp_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg     <= value_next;
        cmp_idx_reg   <= cmp_idx_next;
        found_reg     <= found_next;
        drop_reg      <= drop_next;
        front_reg     <= front_next;
        out_front_reg <= out_front_next;
        out_back_reg  <= out_back_next;
        out_occ_reg   <= out_occ_next;
        out_found_reg <= out_found_next;
        out_drop_reg  <= out_drop_next;
    end

endmodule

// ===== hw/rtl/rfs_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the reversible search FIFO, bound to the top level.
module rfs_checker
    import rfs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input logic         clk,
    input logic         rst_n,
    input logic         rsp_valid,
    input logic         rsp_ready,
    input word_t        front_value,
    input word_t        back_value,
    input occ_t         occupancy,
    input found_t       found_index,
    input logic         overflow_drop
);

    localparam bit SMALL = (DEPTH < 32);

    // A dropped enqueue only happens with the store full.
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && overflow_drop && SMALL |-> occupancy == OCC_W'(DEPTH))
        else $error("overflow drop reported while not full");

    // An empty queue reports -1 at both ends.
    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && occupancy == '0 && SMALL |->
            front_value == WORD_EMPTY && back_value == WORD_EMPTY)
        else $error("empty queue reported a front or back word");

    // With one word held, front and back are the same word.
    a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && occupancy == OCC_W'(1) && SMALL |-> front_value == back_value)
        else $error("single word queue reported differing ends");

    // A match index lies inside the held words.
    a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && found_index != FOUND_NONE && SMALL |->
            OCC_W'(found_index) < occupancy)
        else $error("match index beyond occupancy");

    // A stalled status holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(front_value)
            && $stable(back_value) && $stable(occupancy) && $stable(found_index)
            && $stable(overflow_drop))
        else $error("stalled status changed");

endmodule

bind reversible_fifo_with_search_core rfs_checker #(
    .DEPTH (DEPTH)
) u_rfs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .front_value   (rsp.front_value),
    .back_value    (rsp.back_value),
    .occupancy     (rsp.occupancy),
    .found_index   (rsp.found_index),
    .overflow_drop (rsp.overflow_drop)
);
